[hdl/brr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_pkg
// Shared types, constants and the nibble decode function for the BRR decoder.
// ----------------------------------------------------------------------------
package brr_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

  localparam logic [3:0]  BLOCK_BYTES = 4'd8;
  localparam logic [3:0]  RANGE_MAX   = 4'd12;
  localparam logic [15:0] NEG_CLIP    = 16'hF800;

  localparam logic [1:0] PRED_NONE = 2'd0;
  localparam logic [1:0] PRED_ONE  = 2'd1;
  localparam logic [1:0] PRED_TWO  = 2'd2;
  localparam logic [1:0] PRED_THREE = 2'd3;

  typedef struct packed {
    logic [2:0] voice;
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  voice_tag;
    logic [15:0] sample;
    logic        second_nibble;
    logic        block_end;
    logic        end_flag;
    logic        loop_flag;
  } out_item_t;

  // one data byte with the header state it decodes under
  typedef struct packed {
    logic [2:0] voice;
    logic [7:0] data_byte;
    logic [3:0] shift_range;
    logic [1:0] predictor_select;
    logic [1:0] header_flags;
    logic       last;
  } job_t;

  function automatic logic [15:0] brr_decode(input logic [3:0]  nib,
                                             input logic [3:0]  rng,
                                             input logic [1:0]  sel,
                                             input logic [15:0] prev1,
                                             input logic [15:0] prev2);
    logic signed [16:0] n17;
    logic signed [16:0] scaled;
    logic [15:0]        base;
    logic signed [21:0] t;
    logic signed [21:0] a;
    logic signed [21:0] b;
    logic signed [21:0] acc;
    n17    = {{13{nib[3]}}, nib};
    scaled = n17 <<< rng;
    if (rng > RANGE_MAX) begin
      base = nib[3] ? NEG_CLIP : 16'd0;
    end else begin
      base = scaled[15:0];
    end
    t = {{6{base[15]}}, base};
    a = {{6{prev1[15]}}, prev1};
    b = {{6{prev2[15]}}, prev2};
    unique case (sel)
      PRED_NONE: acc = t;
      PRED_ONE:  acc = t + a + ((-a) >>> 4);
      PRED_TWO:  acc = t + (a <<< 1) + ((-(a + (a <<< 1))) >>> 5) - b + (b >>> 4);
      PRED_THREE: acc = t + (a <<< 1) + ((-((a <<< 3) + (a <<< 2) + a)) >>> 6)
                        - b + ((b + (b <<< 1)) >>> 4);
      default:   acc = t;
    endcase
    return acc[15:0];
  endfunction

endpackage

[hdl/brr_adpcm_block_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_adpcm_block_decoder_core
// BRR ADPCM decoder for up to eight voices, one byte per transfer.
// ----------------------------------------------------------------------------
// path: the first sample of a data byte passes the queue, the job register and
//   the output register; the second follows (with an empty queue and no output stall)
// throughput: set by the single sample unit, one nibble per cycle unless the output
//   stalls, with no gap between queued bytes; header bytes need no queue slot
// reset: clears all voice state, so each voice's next byte is a header
module brr_adpcm_block_decoder_core import brr_pkg::*; #(
  parameter int VOICES = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic queue_full;
  logic queue_empty;
  logic push;
  logic pop;
  job_t push_data;
  job_t queue_head;

  brr_front #(.VOICES(VOICES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  brr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (queue_full),
    .empty     (queue_empty),
    .head      (queue_head)
  );

  brr_back #(.VOICES(VOICES)) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .queue_head  (queue_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

[hdl/brr_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_queue
// Small job queue between the byte classifier and the sample unit.
// ----------------------------------------------------------------------------
module brr_queue import brr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  job_t                mem [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wr_ptr;
  logic [QUEUE_PW-1:0] rd_ptr;
  logic [QUEUE_PW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == (QUEUE_PW + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/brr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_front
// Accepts bytes, tracks per-voice block position and header state, and
// queues data bytes with their header settings for the sample unit.
// ----------------------------------------------------------------------------
module brr_front import brr_pkg::*; #(
  parameter int VOICES = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     queue_full,
  output logic     push,
  output job_t     push_data
);

  localparam int         NSLOT     = (VOICES < 8) ? VOICES : 8;
  localparam int         IW        = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam logic [4:0] VOICE_LIM = 5'(VOICES);

  logic [3:0] shift_range      [NSLOT];
  logic [1:0] predictor_select [NSLOT];
  logic [1:0] header_flags     [NSLOT];
  logic [3:0] bytes_left       [NSLOT];

  logic          accept;
  logic          in_range;
  logic          is_header;
  logic [IW-1:0] idx;
  logic [3:0]    left_dec;

  assign in_stall  = queue_full;
  assign accept    = in_valid && !queue_full;
  assign idx       = in_data.voice[IW-1:0];
  assign in_range  = ({2'b00, in_data.voice} < VOICE_LIM);
  assign is_header = in_data.restart || (bytes_left[idx] == 4'd0);
  assign left_dec  = bytes_left[idx] - 4'd1;
  assign push      = accept && in_range && !is_header;

  always_comb begin
    push_data.voice            = in_data.voice;
    push_data.data_byte        = in_data.data_byte;
    push_data.shift_range      = shift_range[idx];
    push_data.predictor_select = predictor_select[idx];
    push_data.header_flags     = header_flags[idx];
    push_data.last             = (left_dec == 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSLOT; i++) begin
        shift_range[i]      <= '0;
        predictor_select[i] <= '0;
        header_flags[i]     <= '0;
        bytes_left[i]       <= '0;
      end
    end else if (accept && in_range) begin
      if (is_header) begin
        shift_range[idx]      <= in_data.data_byte[7:4];
        predictor_select[idx] <= in_data.data_byte[3:2];
        header_flags[idx]     <= in_data.data_byte[1:0];
        bytes_left[idx]       <= BLOCK_BYTES;
      end else begin
        bytes_left[idx] <= left_dec;
      end
    end
  end

endmodule

[hdl/brr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_back
// Sample unit: decodes one nibble per cycle unless the output stalls, against
// the voice's two previous samples, and holds each sample in an output register.
// ----------------------------------------------------------------------------
module brr_back import brr_pkg::*; #(
  parameter int VOICES = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      queue_empty,
  input  job_t      queue_head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int NSLOT = (VOICES < 8) ? VOICES : 8;
  localparam int IW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;

  logic [15:0] prev_sample_one [NSLOT];
  logic [15:0] prev_sample_two [NSLOT];

  job_t        job;
  logic        job_valid;
  logic        phase;
  logic        advance;
  logic        load;
  logic [3:0]  nib;
  logic [IW-1:0] idx;
  logic [15:0] sample_next;
  logic        end_here;

  assign advance = job_valid && (!out_valid || !out_stall);
  // pull the next job when idle or as the second nibble goes out
  assign load    = !job_valid || (advance && phase);
  assign pop     = load && !queue_empty;
  assign nib     = phase ? job.data_byte[3:0] : job.data_byte[7:4];
  assign idx     = job.voice[IW-1:0];
  assign end_here = phase && job.last;
  assign sample_next = brr_decode(nib, job.shift_range, job.predictor_select,
                                  prev_sample_one[idx], prev_sample_two[idx]);

  always_ff @(posedge clk) begin
    if (load && !queue_empty) begin
      job <= queue_head;
    end
    if (advance) begin
      out_data.voice_tag     <= job.voice;
      out_data.sample        <= sample_next;
      out_data.second_nibble <= phase;
      out_data.block_end     <= end_here;
      out_data.end_flag      <= end_here && job.header_flags[0];
      out_data.loop_flag     <= end_here && job.header_flags[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NSLOT; i++) begin
        prev_sample_one[i] <= '0;
        prev_sample_two[i] <= '0;
      end
    end else begin
      if (advance) begin
        out_valid            <= 1'b1;
        phase                <= !phase;
        prev_sample_two[idx] <= prev_sample_one[idx];
        prev_sample_one[idx] <= sample_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        job_valid <= !queue_empty;
      end
    end
  end

endmodule

[hdl/brr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_port_checks
// Port-level checks on the decoder's input and output channels.
// ----------------------------------------------------------------------------
module brr_port_checks import brr_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled input transfer stays offered with the same payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input payload changed under stall");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output valid dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("output payload changed under stall");

  // block end only on the low nibble of a byte
  a_end_on_second: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.block_end |-> out_data.second_nibble)
    else $error("block end on a first-nibble sample");

  a_flags_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.block_end |-> !out_data.end_flag && !out_data.loop_flag)
    else $error("header flags reported off block end");

endmodule

bind brr_adpcm_block_decoder_core brr_port_checks u_brr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
